// File: hw/rtl/ioq_pkg.sv
// ioq_pkg: types, codes and constants of the in-order request completion queue.
// Used by ioq_cell and in_order_request_completion_queue; depends on nothing.
package ioq_pkg;

  localparam int TAG_W           = 16;
  localparam int DLY_W           = 8;
  localparam int MAX_RESULTS     = 17;
  localparam int RES_W           = 5;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int REG_IDX_W       = 2;
  localparam int CFG_W           = 8;

  localparam logic [1:0] FUNC_REQ   = 2'd0;
  localparam logic [1:0] FUNC_RSP   = 2'd1;
  localparam logic [1:0] FUNC_RETRY = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_RSP   = 2'd2;
  localparam logic [1:0] KIND_RETRY = 2'd3;

  localparam logic [1:0] MODE_SERIAL = 2'd0;
  localparam logic [1:0] MODE_PIPE   = 2'd1;
  localparam logic [1:0] MODE_UNORD  = 2'd2;
  localparam logic [1:0] MODE_ALT    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PUSH_LAT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_POP_LAT = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [TAG_W-1:0] tag;
    logic             is_read;
    logic             cache_ready;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TAG_W-1:0] out_tag;
    logic             out_is_read;
    logic [DLY_W-1:0] delay_cycles;
    logic             accepted;
    logic             bus_full;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TAG_W-1:0] tag;
    logic             rd;
    logic [DLY_W-1:0] dly;
  } res_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             rd;
    logic             done;
  } cell_data_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic             mark;
    logic [TAG_W-1:0] tag;
    logic             rd;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SENDP,
    S_DRAIN,
    S_POP,
    S_SERNEXT,
    S_RETIRE,
    S_FINISH,
    S_EMIT
  } state_t;

endpackage

// File: hw/rtl/ioq_cell.sv
// ioq_cell: one queue slot; shifts toward the head on pop, loads at the tail,
// and takes part in the first-match response search. Depends on ioq_pkg.
module ioq_cell import ioq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic       in_range,
  input  cell_data_t up,
  input  logic       found_in,
  output logic       found_out,
  output cell_data_t data
);

  logic hit;

  assign hit       = in_range && !data.done && (data.tag == ctrl.tag);
  assign found_out = found_in | hit;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data.tag <= up.tag;
      data.rd  <= up.rd;
    end else if (ctrl.load && sel) begin
      data.tag <= ctrl.tag;
      data.rd  <= ctrl.rd;
    end
    if (rst) begin
      data.done <= 1'b0;
    end else if (ctrl.shift) begin
      data.done <= up.done;
    end else if (ctrl.load && sel) begin
      data.done <= 1'b0;
    end else if (ctrl.mark && hit && !found_in) begin
      data.done <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/in_order_request_completion_queue.sv
// in_order_request_completion_queue: ordering queue between bus and cache.
// Depends on ioq_pkg and ioq_cell (a row of QUEUE_DEPTH cells, head at cell 0).
//
//   channel  direction  payload     handshake
//   in       input      in_beat_t   in_valid / in_stall
//   out      output     out_beat_t  out_valid / out_stall
//   cfg      input      8-bit data  cfg_we, cfg_index
//
// One event at a time: accept, execute, then send each request (S_SENDP) in
// pipelined mode or drain or retire each entry (S_DRAIN/S_RETIRE, S_POP), and leave
// that loop; pop and head send on a serial response (S_POP, S_SERNEXT); close, load
// the first beat, then the next result beat each time one is taken on out (17 at most).
// rst is synchronous; it clears the queue, flags and registers to defaults.
// in_stall is high from acceptance until the last beat is taken; out_stall holds it.
module in_order_request_completion_queue import ioq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int LW = (CW > 5) ? CW : 5;

  logic [1:0]       ordering_mode;
  logic [4:0]       queue_limit;
  logic [DLY_W-1:0] push_latency;
  logic [DLY_W-1:0] pop_latency;

  state_t state, state_next, ret, ret_next;
  logic [CW-1:0]    count, count_next, sent_upto, sent_next;
  logic             held_valid, held_valid_next, held_rd, held_rd_next;
  logic [TAG_W-1:0] held_tag, held_tag_next;
  logic             cache_blocked, cache_blocked_next;
  logic             bus_blocked, bus_blocked_next;
  logic             retry_owed, retry_owed_next;
  logic [RES_W-1:0] nres, nres_next, rd_ptr, rd_ptr_next;

  logic [1:0]       it_func;
  logic [TAG_W-1:0] it_tag;
  logic             it_rd, it_ready, acc, acc_next;

  res_entry_t       rbuf [MAX_RESULTS];
  logic             bw_en, emit_req, send_req, out_load, out_valid_next;
  res_entry_t       emit_data;
  logic [TAG_W-1:0] send_tag;
  logic             send_rd;
  logic [DLY_W-1:0] send_dly;

  cell_ctrl_t       cc;
  cell_data_t       cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found;
  cell_data_t       sel_cell;

  logic [1:0]       mode;
  logic [LW-1:0]    lim;
  logic             in_take, out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign mode     = (ordering_mode == MODE_ALT) ? MODE_UNORD : ordering_mode;

  always_comb begin
    if (queue_limit == 5'd0) begin
      lim = LW'(1);
    end else if (LW'(queue_limit) > LW'(QUEUE_DEPTH)) begin
      lim = LW'(QUEUE_DEPTH);
    end else begin
      lim = LW'(queue_limit);
    end
  end

  // cell row
  assign found[0] = 1'b0;
  assign sel_cell = cells[sent_upto[IW-1:0]];

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    cell_data_t up_k;
    if (k == QUEUE_DEPTH - 1) begin : g_top
      assign up_k = '0;
    end else begin : g_mid
      assign up_k = cells[k+1];
    end
    ioq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cc),
      .sel       (CW'(k) == count),
      .in_range  (CW'(k) < count),
      .up        (up_k),
      .found_in  (found[k]),
      .found_out (found[k+1]),
      .data      (cells[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering_mode <= MODE_PIPE;
      queue_limit   <= 5'd16;
      push_latency  <= '0;
      pop_latency   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     ordering_mode <= cfg_data[1:0];
        REG_LIMIT:    queue_limit   <= cfg_data[4:0];
        REG_PUSH_LAT: push_latency  <= cfg_data;
        REG_POP_LAT:  pop_latency   <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_next         = state;
    ret_next           = ret;
    count_next         = count;
    sent_next          = sent_upto;
    held_valid_next    = held_valid;
    held_tag_next      = held_tag;
    held_rd_next       = held_rd;
    cache_blocked_next = cache_blocked;
    bus_blocked_next   = bus_blocked;
    retry_owed_next    = retry_owed;
    acc_next           = acc;
    nres_next          = nres;
    rd_ptr_next        = rd_ptr;
    out_valid_next     = out_valid;
    out_load           = 1'b0;
    emit_req           = 1'b0;
    emit_data          = '0;
    send_req           = 1'b0;
    send_tag           = '0;
    send_rd            = 1'b0;
    send_dly           = '0;
    cc                 = '0;
    bw_en              = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_take) begin
          acc_next   = 1'b0;
          nres_next  = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (it_func)
          FUNC_REQ: begin
            if (bus_blocked || (count == CW'(QUEUE_DEPTH))) begin
              retry_owed_next  = 1'b1;
              bus_blocked_next = 1'b1;
            end else begin
              acc_next   = 1'b1;
              cc.load    = 1'b1;
              cc.tag     = it_tag;
              cc.rd      = it_rd;
              count_next = count + CW'(1);
              if (LW'(count_next) >= lim) bus_blocked_next = 1'b1;
              if (mode == MODE_SERIAL) begin
                if ((count == '0) && !cache_blocked) begin
                  send_req = 1'b1;
                  send_tag = it_tag;
                  send_rd  = it_rd;
                  send_dly = push_latency;
                end
              end else if (mode == MODE_PIPE) begin
                if (!cache_blocked) state_next = S_SENDP;
              end else begin
                state_next = S_DRAIN;
              end
            end
          end
          FUNC_RSP: begin
            if (mode == MODE_PIPE) begin
              cc.mark    = 1'b1;
              cc.tag     = it_tag;
              state_next = S_RETIRE;
            end else begin
              emit_req       = 1'b1;
              emit_data.kind = KIND_RSP;
              emit_data.tag  = it_tag;
              emit_data.rd   = it_rd;
              emit_data.dly  = it_rd ? pop_latency : '0;
              if (mode == MODE_SERIAL) begin
                ret_next   = S_SERNEXT;
                state_next = S_POP;
              end else begin
                state_next = S_DRAIN;
              end
            end
          end
          FUNC_RETRY: begin
            if (held_valid) begin
              held_valid_next    = 1'b0;
              cache_blocked_next = 1'b0;
              send_req = 1'b1;
              send_tag = held_tag;
              send_rd  = held_rd;
              send_dly = (mode == MODE_SERIAL) ? push_latency : '0;
              if (it_ready) begin
                if (mode == MODE_PIPE) state_next = S_SENDP;
                else if (mode == MODE_UNORD) state_next = S_DRAIN;
              end
            end
          end
          default: ;
        endcase
      end
      S_SENDP: begin
        if ((sent_upto < count) && !cache_blocked) begin
          send_req  = 1'b1;
          send_tag  = sel_cell.tag;
          send_rd   = sel_cell.rd;
          sent_next = sent_upto + CW'(1);
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DRAIN: begin
        if ((count != '0) && !cache_blocked && (nres < RES_W'(MAX_RESULTS - 1))) begin
          send_req   = 1'b1;
          send_tag   = cells[0].tag;
          send_rd    = cells[0].rd;
          ret_next   = S_DRAIN;
          state_next = S_POP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_POP: begin
        state_next = ret;
        if (count != '0) begin
          cc.shift   = 1'b1;
          count_next = count - CW'(1);
          if (sent_upto != '0) sent_next = sent_upto - CW'(1);
          if (bus_blocked && (LW'(count_next) < lim)) begin
            bus_blocked_next = 1'b0;
            if (retry_owed) begin
              retry_owed_next = 1'b0;
              emit_req        = 1'b1;
              emit_data.kind  = KIND_RETRY;
            end
          end
        end
      end
      S_SERNEXT: begin
        state_next = S_FINISH;
        if ((count != '0) && !cache_blocked) begin
          send_req = 1'b1;
          send_tag = cells[0].tag;
          send_rd  = cells[0].rd;
          send_dly = push_latency;
        end
      end
      S_RETIRE: begin
        if ((count != '0) && cells[0].done) begin
          emit_req       = 1'b1;
          emit_data.kind = KIND_RSP;
          emit_data.tag  = cells[0].tag;
          emit_data.rd   = cells[0].rd;
          emit_data.dly  = cells[0].rd ? pop_latency : '0;
          ret_next       = S_RETIRE;
          state_next     = S_POP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (nres == '0) emit_req = 1'b1;
        rd_ptr_next = '0;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_take) begin
          if (rd_ptr < nres) begin
            out_load       = 1'b1;
            out_valid_next = 1'b1;
            rd_ptr_next    = rd_ptr + RES_W'(1);
          end else begin
            out_valid_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (send_req) begin
      if (it_ready) begin
        emit_req       = 1'b1;
        emit_data.kind = KIND_REQ;
        emit_data.tag  = send_tag;
        emit_data.rd   = send_rd;
        emit_data.dly  = send_dly;
      end else begin
        held_valid_next    = 1'b1;
        held_tag_next      = send_tag;
        held_rd_next       = send_rd;
        cache_blocked_next = 1'b1;
      end
    end

    if (emit_req && (nres < RES_W'(MAX_RESULTS))) begin
      bw_en     = 1'b1;
      nres_next = nres + RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      count         <= '0;
      sent_upto     <= '0;
      held_valid    <= 1'b0;
      held_tag      <= '0;
      held_rd       <= 1'b0;
      cache_blocked <= 1'b0;
      bus_blocked   <= 1'b0;
      retry_owed    <= 1'b0;
      acc           <= 1'b0;
      nres          <= '0;
      rd_ptr        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      ret           <= ret_next;
      count         <= count_next;
      sent_upto     <= sent_next;
      held_valid    <= held_valid_next;
      held_tag      <= held_tag_next;
      held_rd       <= held_rd_next;
      cache_blocked <= cache_blocked_next;
      bus_blocked   <= bus_blocked_next;
      retry_owed    <= retry_owed_next;
      acc           <= acc_next;
      nres          <= nres_next;
      rd_ptr        <= rd_ptr_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      it_func  <= in_data.func;
      it_tag   <= in_data.tag;
      it_rd    <= in_data.is_read;
      it_ready <= in_data.cache_ready;
    end
    if (bw_en) rbuf[nres] <= emit_data;
    if (out_load) begin
      out_data.kind         <= rbuf[rd_ptr].kind;
      out_data.out_tag      <= rbuf[rd_ptr].tag;
      out_data.out_is_read  <= rbuf[rd_ptr].rd;
      out_data.delay_cycles <= rbuf[rd_ptr].dly;
      out_data.accepted     <= acc;
      out_data.bus_full     <= bus_blocked;
      out_data.last         <= (rd_ptr_next == nres);
    end
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EMIT))
    else $error("result beat outside emit phase");

  a_held_blocked: assert property (@(posedge clk) disable iff (rst)
    held_valid == cache_blocked)
    else $error("held request and cache block disagree");

  a_sent_in_queue: assert property (@(posedge clk) disable iff (rst)
    (sent_upto <= count) && (count <= CW'(QUEUE_DEPTH)))
    else $error("queue pointers out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (rd_ptr == nres))
    else $error("last beat before all results read");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for in_order_request_completion_queue.
// Mirrors the queue in a local predictor, drives random and directed beats
// with random idling on both channels. Depends on ioq_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import ioq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int PEND_N = 512;
  localparam int EXP_N = 1024;
  localparam int LIVE_N = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  in_order_request_completion_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the queue
  logic [1:0] q_mode;
  logic [4:0] q_limit;
  logic [7:0] q_push_lat, q_pop_lat;
  logic [TAG_W-1:0] q_tag [DEPTH];
  bit q_rd [DEPTH];
  bit q_done [DEPTH];
  int q_head, q_tail, q_count, q_sent;
  bit held_v, cache_blk, bus_blk, retry_owed, ready_now;
  logic [TAG_W:0] held_word;
  res_entry_t beats_buf [MAX_RESULTS];
  int nbeats;

  in_beat_t pend_q [PEND_N];
  int pend_wr, pend_rd;
  out_beat_t exp_q [EXP_N];
  int exp_wr, exp_rd;
  int snd_idle, rcv_idle, errors, n_items, n_beats, hold_kick, hold_seen, hold_left;
  int kind_seen [4];

  function automatic void add_item(in_beat_t b);
    pend_q[pend_wr] = b;
    pend_wr++;
  endfunction

  function automatic int limit_eff();
    if (q_limit == 0) return 1;
    if (q_limit > DEPTH) return DEPTH;
    return q_limit;
  endfunction

  function automatic void put_beat(logic [1:0] k, logic [TAG_W-1:0] t, bit r,
                                   logic [7:0] d);
    if (nbeats >= MAX_RESULTS) return;
    beats_buf[nbeats] = '{kind: k, tag: t, rd: r, dly: d};
    nbeats++;
  endfunction

  function automatic void check_unblock();
    if (bus_blk && q_count < limit_eff()) begin
      bus_blk = 0;
      if (retry_owed) begin
        retry_owed = 0;
        put_beat(KIND_RETRY, '0, 0, '0);
      end
    end
  endfunction

  function automatic void pop_entry();
    if (q_count == 0) return;
    q_done[q_head] = 0;
    q_head = (q_head + 1) % DEPTH;
    q_count--;
    if (q_sent > 0) q_sent--;
    check_unblock();
  endfunction

  function automatic bit send_to_cache(logic [TAG_W-1:0] t, bit r, logic [7:0] d);
    if (ready_now) begin
      put_beat(KIND_REQ, t, r, d);
      return 1;
    end
    held_v = 1;
    held_word = {r, t};
    cache_blk = 1;
    return 0;
  endfunction

  function automatic void send_in_order();
    int i;
    while (q_sent < q_count && !cache_blk) begin
      i = (q_head + q_sent) % DEPTH;
      void'(send_to_cache(q_tag[i], q_rd[i], '0));
      q_sent++;
    end
  endfunction

  function automatic void drain_passthru();
    while (q_count > 0 && !cache_blk && nbeats < MAX_RESULTS - 1) begin
      void'(send_to_cache(q_tag[q_head], q_rd[q_head], '0));
      pop_entry();
    end
  endfunction

  function automatic void predict_event(in_beat_t b);
    logic [1:0] m;
    bit acc, r;
    int i;
    out_beat_t o;
    m = (q_mode == MODE_ALT) ? MODE_UNORD : q_mode;
    acc = 0;
    nbeats = 0;
    ready_now = b.cache_ready;
    if (q_sent > q_count) q_sent = q_count;
    case (b.func)
      FUNC_REQ: begin
        if (bus_blk || q_count >= DEPTH) begin
          retry_owed = 1;
          bus_blk = 1;
        end else begin
          acc = 1;
          q_tag[q_tail] = b.tag;
          q_rd[q_tail] = b.is_read;
          q_done[q_tail] = 0;
          q_tail = (q_tail + 1) % DEPTH;
          q_count++;
          if (q_count >= limit_eff()) bus_blk = 1;
          if (m == MODE_SERIAL) begin
            if (q_count == 1 && !cache_blk) void'(send_to_cache(b.tag, b.is_read, q_push_lat));
          end else if (m == MODE_PIPE) begin
            if (!cache_blk) send_in_order();
          end else begin
            drain_passthru();
          end
        end
      end
      FUNC_RSP: begin
        if (m == MODE_SERIAL) begin
          put_beat(KIND_RSP, b.tag, b.is_read, b.is_read ? q_pop_lat : 8'd0);
          pop_entry();
          if (q_count > 0 && !cache_blk)
            void'(send_to_cache(q_tag[q_head], q_rd[q_head], q_push_lat));
        end else if (m == MODE_PIPE) begin
          for (int j = 0; j < q_count; j++) begin
            i = (q_head + j) % DEPTH;
            if (!q_done[i] && q_tag[i] == b.tag) begin
              q_done[i] = 1;
              break;
            end
          end
          while (q_count > 0 && q_done[q_head]) begin
            r = q_rd[q_head];
            put_beat(KIND_RSP, q_tag[q_head], r, r ? q_pop_lat : 8'd0);
            pop_entry();
          end
        end else begin
          put_beat(KIND_RSP, b.tag, b.is_read, b.is_read ? q_pop_lat : 8'd0);
          drain_passthru();
        end
      end
      FUNC_RETRY: begin
        if (held_v) begin
          held_v = 0;
          cache_blk = 0;
          if (send_to_cache(held_word[TAG_W-1:0], held_word[TAG_W],
                            m == MODE_SERIAL ? q_push_lat : 8'd0)) begin
            if (m == MODE_PIPE) send_in_order();
            else if (m == MODE_UNORD) drain_passthru();
          end
        end
      end
      default: ;
    endcase
    if (nbeats == 0) put_beat(KIND_NONE, '0, 0, '0);
    for (int k = 0; k < nbeats; k++) begin
      o.kind = beats_buf[k].kind;
      o.out_tag = beats_buf[k].tag;
      o.out_is_read = beats_buf[k].rd;
      o.delay_cycles = beats_buf[k].dly;
      o.accepted = acc;
      o.bus_full = bus_blk;
      o.last = (k == nbeats - 1);
      exp_q[exp_wr % EXP_N] = o;
      exp_wr++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_event(in_data);
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_rd < pend_wr && $urandom_range(99) >= snd_idle) begin
          in_data <= pend_q[pend_rd];
          pend_rd++;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 120;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      n_beats++;
      kind_seen[out_data.kind]++;
      if (exp_rd >= exp_wr) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = exp_q[exp_rd % EXP_N];
        exp_rd++;
        if (want !== out_data) begin
          errors++;
          if (errors <= 10) $display("beat mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_MODE: q_mode = v[1:0];
      REG_LIMIT: q_limit = v[4:0];
      REG_PUSH_LAT: q_push_lat = v;
      default: q_pop_lat = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pend_rd < pend_wr || in_valid || exp_rd < exp_wr) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic setup(logic [1:0] m, logic [7:0] lim, logic [7:0] pu, logic [7:0] po);
    wait_quiet();
    write_reg(REG_MODE, m);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_PUSH_LAT, pu);
    write_reg(REG_POP_LAT, po);
  endtask

  function automatic in_beat_t mk(logic [1:0] f, logic [TAG_W-1:0] t, bit r, bit c);
    return '{func: f, tag: t, is_read: r, cache_ready: c};
  endfunction

  logic [TAG_W-1:0] live_tags [LIVE_N];
  int live_n;

  task automatic random_items(int n);
    int r, j;
    in_beat_t b;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      b.is_read = $urandom_range(1);
      b.cache_ready = ($urandom_range(3) != 0);
      b.tag = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
      if (r < 45) begin
        b.func = FUNC_REQ;
        if (live_n < LIVE_N) begin
          live_tags[live_n] = b.tag;
          live_n++;
        end
      end else if (r < 85) begin
        b.func = FUNC_RSP;
        if (live_n > 0 && $urandom_range(9) < 8) begin
          j = $urandom_range(live_n - 1);
          b.tag = live_tags[j];
          live_tags[j] = live_tags[live_n - 1];
          live_n--;
        end
      end else if (r < 97) begin
        b.func = FUNC_RETRY;
      end else begin
        b.func = 2'd3;
      end
      add_item(b);
    end
  endtask

  initial begin
    #2000000000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    q_mode = MODE_PIPE;
    q_limit = 5'd16;
    q_push_lat = '0;
    q_pop_lat = '0;
    q_head = 0; q_tail = 0; q_count = 0; q_sent = 0;
    held_v = 0; cache_blk = 0; bus_blk = 0; retry_owed = 0;
    held_word = '0;
    foreach (q_done[i]) q_done[i] = 0;
    snd_idle = 32; rcv_idle = 49;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // pipelined defaults: extremes, held request, out-of-order completion
    add_item(mk(FUNC_REQ, 16'h0000, 1, 1));
    add_item(mk(FUNC_REQ, 16'hFFFF, 0, 0));
    add_item(mk(FUNC_REQ, 16'h5A5A, 1, 1));
    add_item(mk(FUNC_RETRY, 16'h1234, 0, 1));
    add_item(mk(FUNC_RETRY, 16'h1234, 0, 1));
    add_item(mk(FUNC_RSP, 16'h5A5A, 1, 1));
    add_item(mk(FUNC_RSP, 16'h7777, 0, 1));
    add_item(mk(FUNC_RSP, 16'hFFFF, 0, 1));
    add_item(mk(FUNC_RSP, 16'h0000, 1, 1));
    add_item(mk(2'd3, 16'hAAAA, 1, 0));
    // serial, tight limit: refusal and owed bus retry
    setup(MODE_SERIAL, 8'd2, 8'd255, 8'd255);
    add_item(mk(FUNC_RSP, 16'h0042, 1, 1));
    add_item(mk(FUNC_REQ, 16'h0001, 1, 0));
    add_item(mk(FUNC_REQ, 16'h0002, 0, 1));
    add_item(mk(FUNC_REQ, 16'h0003, 1, 1));
    add_item(mk(FUNC_RETRY, 16'h0000, 0, 1));
    add_item(mk(FUNC_RSP, 16'h0001, 1, 1));
    add_item(mk(FUNC_RSP, 16'h0002, 0, 1));
    // unordered, limit zero and above depth
    setup(MODE_UNORD, 8'd0, 8'd0, 8'd1);
    add_item(mk(FUNC_REQ, 16'h0010, 1, 1));
    add_item(mk(FUNC_RSP, 16'h0010, 1, 1));
    setup(MODE_ALT, 8'd31, 8'd7, 8'd0);
    add_item(mk(FUNC_REQ, 16'h0011, 0, 0));
    add_item(mk(FUNC_REQ, 16'h0012, 1, 1));
    add_item(mk(FUNC_RETRY, 16'h0000, 0, 1));
    add_item(mk(FUNC_RSP, 16'h0012, 1, 1));

    setup(MODE_PIPE, 8'd16, 8'd0, 8'd200);
    random_items(25);
    wait (pend_wr - pend_rd < 15);
    hold_kick = hold_kick + 1;
    random_items(20);
    setup(MODE_SERIAL, 8'd1, 8'd3, 8'd9);
    random_items(30);
    snd_idle = 49; rcv_idle = 32;
    setup(MODE_UNORD, 8'd16, 8'd100, 8'd255);
    random_items(35);
    setup(MODE_PIPE, 8'd4, 8'd255, 8'd0);
    random_items(35);
    snd_idle = 0; rcv_idle = 0;
    setup(MODE_ALT, 8'd8, 8'd1, 8'd17);
    random_items(30);
    setup(MODE_PIPE, 8'd12, 8'd0, 8'd255);
    random_items(12);

    wait_quiet();
    $display("ran %0d events over all ordering modes and limits; %0d beats checked",
             n_items, n_beats);
    $display("beats by kind: none %0d, to cache %0d, to bus %0d, bus retry %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (errors == 0 && exp_rd == exp_wr) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", errors, exp_wr - exp_rd);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
